[rtl/glyph_to_framebuffer_blitter_top_assert.svh]
// Assertion macros shared by the blitter checker.
`ifndef GLYPH_TO_FRAMEBUFFER_BLITTER_TOP_ASSERT_SVH
`define GLYPH_TO_FRAMEBUFFER_BLITTER_TOP_ASSERT_SVH

// same-cycle implication, reset masked
`define GFB_ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("gfb assertion failed");

// next-cycle implication, reset masked
`define GFB_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("gfb assertion failed");

`endif

[rtl/gfb_pkg.sv]
// Shared types and constants of the glyph blitter.
`timescale 1ns / 1ps
`default_nettype none
package gfb_pkg;

	localparam int POS_W    = 12;
	localparam int DIM_W    = 13;
	localparam int IDX_W    = 2 * DIM_W;
	localparam int OUT_IDX_W = 24;
	localparam int COLOR_W  = 32;
	localparam int BITS_W   = 8;
	localparam int CODE_W   = 8;
	localparam int GROW_W   = 3;
	localparam int CFG_IDX_W = 2;

	typedef logic [1:0] op_t;
	localparam op_t OP_LOAD = 2'd0;
	localparam op_t OP_DRAW = 2'd1;
	localparam op_t OP_PUT  = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_PRESENT = 2'd0;
	localparam cfg_idx_t CFG_WIDTH   = 2'd1;
	localparam cfg_idx_t CFG_HEIGHT  = 2'd2;

	// leftmost pixel is bit 7
	localparam logic [BITS_W-1:0] BIT_SELECT [8] = '{
		8'd128, 8'd64, 8'd32, 8'd16, 8'd8, 8'd4, 8'd2, 8'd1
	};

endpackage
`default_nettype wire

[rtl/gfb_ram.sv]
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module gfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output      logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

[rtl/gfb_mul.sv]
// Shared 13x13 multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module gfb_mul (
	input  wire logic                      clk,
	input  wire logic [gfb_pkg::DIM_W-1:0] a,
	input  wire logic [gfb_pkg::DIM_W-1:0] b,
	output      logic [gfb_pkg::IDX_W-1:0] product_s1
);

	always_ff @(posedge clk) begin
		product_s1 <= gfb_pkg::IDX_W'(a) * gfb_pkg::IDX_W'(b);
	end

endmodule
`default_nettype wire

[rtl/glyph_to_framebuffer_blitter_top.sv]
// Top level: glyph store, sequencer and pixel word generator.
// Load glyph row: written to the glyph store on accept, no word out, sequencer stays idle.
// Draw: setup states S_LIM, S_BASE, S_ADD on the shared multiplier (width*height, y*width),
//   then one word per cycle while the output is not stalled, GLYPH_WIDTH*GLYPH_HEIGHT words
//   (64 by default); no new item is taken until the last word has been emitted.
// Put pixel: one word after the same setup; no new item until it is emitted. Reset clears config,
//   sequencer and out valid.
`timescale 1ns / 1ps
`default_nettype none
module glyph_to_framebuffer_blitter_top #(
	parameter int GLYPH_WIDTH  = 8,
	parameter int GLYPH_HEIGHT = 8,
	parameter int CHAR_COUNT   = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [gfb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gfb_pkg::DIM_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire logic [1:0]                    op,
	input  wire logic [gfb_pkg::CODE_W-1:0]    char_code,
	input  wire logic [gfb_pkg::GROW_W-1:0]    glyph_row,
	input  wire logic [gfb_pkg::BITS_W-1:0]    row_bits,
	input  wire logic [gfb_pkg::POS_W-1:0]     pos_x,
	input  wire logic [gfb_pkg::POS_W-1:0]     pos_y,
	input  wire logic [gfb_pkg::COLOR_W-1:0]   fg_color,
	input  wire logic [gfb_pkg::COLOR_W-1:0]   bg_color,
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic                          write_valid,
	output      logic [gfb_pkg::OUT_IDX_W-1:0] pixel_index,
	output      logic [gfb_pkg::COLOR_W-1:0]   pixel_color,
	output      logic                          last
);

	localparam int DEPTH  = CHAR_COUNT * GLYPH_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COL_W  = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
	localparam int ROW_W  = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
	localparam int IDX_W  = gfb_pkg::IDX_W;
	localparam int DIM_W  = gfb_pkg::DIM_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LIM  = 3'd1;
	localparam logic [2:0] S_BASE = 3'd2;
	localparam logic [2:0] S_ADD  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0] state_q;

	logic             present_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	logic                          is_draw_q;
	logic [gfb_pkg::CODE_W-1:0]    code_q;
	logic [gfb_pkg::POS_W-1:0]     px_q;
	logic [gfb_pkg::POS_W-1:0]     py_q;
	logic [gfb_pkg::COLOR_W-1:0]   fg_q;
	logic [gfb_pkg::COLOR_W-1:0]   bg_q;
	logic [IDX_W-1:0]              limit_q;
	logic [IDX_W-1:0]              idx_q;
	logic [IDX_W-1:0]              row_step_q;
	logic [COL_W-1:0]              col_q;
	logic [ROW_W-1:0]              row_q;

	logic                          out_valid_q;
	logic                          write_valid_q;
	logic [gfb_pkg::OUT_IDX_W-1:0] pixel_index_q;
	logic [gfb_pkg::COLOR_W-1:0]   pixel_color_q;
	logic                          last_q;

	logic                          accept;
	logic                          load_ok;
	logic                          draw_ok;
	logic [ADDR_W-1:0]             wr_addr;
	logic [ADDR_W-1:0]             rd_addr;
	logic [ROW_W-1:0]              rd_row;
	logic                          rd_en;
	logic [gfb_pkg::BITS_W-1:0]    pattern;
	logic [DIM_W-1:0]              mul_a;
	logic [IDX_W-1:0]              product_s1;
	logic                          emit;
	logic                          col_last;
	logic                          row_last;
	logic                          pix_last;
	logic                          pix_ok;
	logic [gfb_pkg::COLOR_W-1:0]   pix_color;

	assign accept  = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign load_ok = (int'(char_code) < CHAR_COUNT) && (int'(glyph_row) < GLYPH_HEIGHT);
	assign draw_ok = (int'(char_code) < CHAR_COUNT);
	assign wr_addr = ADDR_W'(int'(char_code) * GLYPH_HEIGHT + int'(glyph_row));

	// next row is fetched while the last column of the current one goes out
	assign rd_row  = (state_q == S_ADD) ? '0 : ROW_W'(row_q + ROW_W'(1));
	assign rd_addr = ADDR_W'(int'(code_q) * GLYPH_HEIGHT + int'(rd_row));
	assign rd_en   = (state_q == S_ADD) || (emit && col_last && !row_last);

	gfb_ram #(
		.WIDTH (gfb_pkg::BITS_W),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_glyph_ram (
		.clk    (clk),
		.wr_en  (accept && (op == gfb_pkg::OP_LOAD) && load_ok),
		.wr_addr(wr_addr),
		.wr_data(row_bits),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(pattern)
	);

	assign mul_a = (state_q == S_LIM) ? height_q : DIM_W'(py_q);

	gfb_mul u_mul (
		.clk       (clk),
		.a         (mul_a),
		.b         (width_q),
		.product_s1(product_s1)
	);

	assign emit     = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign col_last = (col_q == COL_W'(GLYPH_WIDTH - 1));
	assign row_last = (row_q == ROW_W'(GLYPH_HEIGHT - 1));
	assign pix_last = !is_draw_q || (col_last && row_last);
	assign pix_ok   = present_q && (idx_q < limit_q) &&
		(idx_q[IDX_W-1:gfb_pkg::OUT_IDX_W] == '0);
	assign pix_color = (!is_draw_q || ((pattern & gfb_pkg::BIT_SELECT[3'(col_q)]) != '0)) ?
		fg_q : bg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			width_q   <= '0;
			height_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gfb_pkg::CFG_PRESENT: present_q <= cfg_data[0];
				gfb_pkg::CFG_WIDTH:   width_q   <= cfg_data;
				gfb_pkg::CFG_HEIGHT:  height_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && ((op == gfb_pkg::OP_PUT) ||
						((op == gfb_pkg::OP_DRAW) && draw_ok))) begin
						state_q <= S_LIM;
					end
				end
				S_LIM:  state_q <= S_BASE;
				S_BASE: state_q <= S_ADD;
				S_ADD:  state_q <= S_EMIT;
				S_EMIT: begin
					if (emit) begin
						out_valid_q <= 1'b1;
						if (pix_last) begin
							state_q <= S_IDLE;
							col_q   <= '0;
							row_q   <= '0;
						end else if (col_last) begin
							col_q <= '0;
							row_q <= ROW_W'(row_q + ROW_W'(1));
						end else begin
							col_q <= COL_W'(col_q + COL_W'(1));
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_draw_q <= (op == gfb_pkg::OP_DRAW);
			code_q    <= char_code;
			px_q      <= pos_x;
			py_q      <= pos_y;
			fg_q      <= fg_color;
			bg_q      <= bg_color;
		end
		if (state_q == S_LIM) begin
			row_step_q <= IDX_W'(width_q) - IDX_W'(GLYPH_WIDTH - 1);
		end
		if (state_q == S_BASE) begin
			limit_q <= product_s1;
		end
		if (state_q == S_ADD) begin
			idx_q <= product_s1 + IDX_W'(px_q);
		end else if (emit) begin
			idx_q <= idx_q + (col_last ? row_step_q : IDX_W'(1));
		end
		if (emit) begin
			write_valid_q <= pix_ok;
			pixel_index_q <= pix_ok ? idx_q[gfb_pkg::OUT_IDX_W-1:0] : '0;
			pixel_color_q <= pix_ok ? pix_color : '0;
			last_q        <= pix_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign write_valid = write_valid_q;
	assign pixel_index = pixel_index_q;
	assign pixel_color = pixel_color_q;
	assign last        = last_q;

endmodule
`default_nettype wire

[rtl/gfb_checker.sv]
// Port-level checker for the blitter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "glyph_to_framebuffer_blitter_top_assert.svh"
module gfb_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic [1:0]                    op,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic                          write_valid,
	input wire logic [gfb_pkg::OUT_IDX_W-1:0] pixel_index,
	input wire logic [gfb_pkg::COLOR_W-1:0]   pixel_color,
	input wire logic                          last
);

	`GFB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(pixel_index) && $stable(pixel_color) && $stable(last))
	`GFB_ASSERT_SAME(a_invalid_zero, clk, arst_n, out_valid && !write_valid, (pixel_index == '0) && (pixel_color == '0))
	`GFB_ASSERT_NEXT(a_put_busy, clk, arst_n, in_valid && !in_stall && (op == gfb_pkg::OP_PUT), in_stall)
	`GFB_ASSERT_NEXT(a_word_follows, clk, arst_n, out_valid && !out_stall && !last, out_valid)
	`GFB_ASSERT_SAME(a_busy_mid_item, clk, arst_n, out_valid && !last, in_stall)

endmodule

bind glyph_to_framebuffer_blitter_top gfb_checker u_gfb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.op         (op),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.write_valid(write_valid),
	.pixel_index(pixel_index),
	.pixel_color(pixel_color),
	.last       (last)
);
`default_nettype wire

[verif/glyph_to_framebuffer_blitter_top_tb.sv]
// Self-checking testbench for the glyph blitter: predicted pixel words vs. the output stream.
`timescale 1ns / 1ps
module glyph_to_framebuffer_blitter_top_tb;

	localparam int GLYPH_W = 8;
	localparam int GLYPH_H = 8;
	localparam int CHARS = 256;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_WAIT = 17;
	localparam gfb_pkg::op_t OP_UNUSED = 2'd3;
	localparam longint unsigned INDEX_SPAN = 64'd1 << gfb_pkg::OUT_IDX_W;

	typedef struct {
		logic                          write_valid;
		logic [gfb_pkg::OUT_IDX_W-1:0] pixel_index;
		logic [gfb_pkg::COLOR_W-1:0]   pixel_color;
		logic                          last;
	} pixel_write_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [gfb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [gfb_pkg::DIM_W-1:0]     cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic [1:0]                    op;
	logic [gfb_pkg::CODE_W-1:0]    char_code;
	logic [gfb_pkg::GROW_W-1:0]    glyph_row;
	logic [gfb_pkg::BITS_W-1:0]    row_bits;
	logic [gfb_pkg::POS_W-1:0]     pos_x;
	logic [gfb_pkg::POS_W-1:0]     pos_y;
	logic [gfb_pkg::COLOR_W-1:0]   fg_color;
	logic [gfb_pkg::COLOR_W-1:0]   bg_color;
	logic                          out_valid;
	logic                          out_stall;
	logic                          write_valid;
	logic [gfb_pkg::OUT_IDX_W-1:0] pixel_index;
	logic [gfb_pkg::COLOR_W-1:0]   pixel_color;
	logic                          last;

	// shadow of the block: glyph rows, which rows were loaded, screen settings
	logic [gfb_pkg::BITS_W-1:0] font_rows [CHARS*GLYPH_H];
	bit                         font_row_set [CHARS*GLYPH_H];
	logic [gfb_pkg::CODE_W-1:0] ready_codes [$];
	bit                         fb_present;
	longint unsigned            fb_width;
	longint unsigned            fb_height;

	pixel_write_t pending_writes [$];

	bit          pacing_off;
	int unsigned items_sent, noise_sent, draws_sent, puts_sent;
	int unsigned words_checked, valid_words, mismatches, screens_used;

	glyph_to_framebuffer_blitter_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.char_code   (char_code),
		.glyph_row   (glyph_row),
		.row_bits    (row_bits),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.fg_color    (fg_color),
		.bg_color    (bg_color),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.write_valid (write_valid),
		.pixel_index (pixel_index),
		.pixel_color (pixel_color),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic pixel_write_t make_write(longint unsigned x, longint unsigned y,
		logic [gfb_pkg::COLOR_W-1:0] color, bit is_last);
		pixel_write_t w;
		longint unsigned idx;
		longint unsigned limit;
		idx = x + y * fb_width;
		limit = fb_width * fb_height;
		w.write_valid = fb_present && (idx < limit) && (idx < INDEX_SPAN);
		w.pixel_index = w.write_valid ? idx[gfb_pkg::OUT_IDX_W-1:0] : '0;
		w.pixel_color = w.write_valid ? color : '0;
		w.last = is_last;
		return w;
	endfunction

	function automatic bit glyph_ready(logic [gfb_pkg::CODE_W-1:0] code);
		for (int r = 0; r < GLYPH_H; r++)
			if (!font_row_set[code * GLYPH_H + r])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void compute_pixel_writes(gfb_pkg::op_t o,
		logic [gfb_pkg::CODE_W-1:0] code, logic [gfb_pkg::GROW_W-1:0] grow,
		logic [gfb_pkg::BITS_W-1:0] bits, logic [gfb_pkg::POS_W-1:0] x,
		logic [gfb_pkg::POS_W-1:0] y, logic [gfb_pkg::COLOR_W-1:0] fg,
		logic [gfb_pkg::COLOR_W-1:0] bg);
		logic [gfb_pkg::BITS_W-1:0] pattern;
		case (o)
			gfb_pkg::OP_LOAD: begin
				font_rows[code * GLYPH_H + grow] = bits;
				font_row_set[code * GLYPH_H + grow] = 1'b1;
			end
			gfb_pkg::OP_PUT: pending_writes.push_back(make_write(x, y, fg, 1'b1));
			gfb_pkg::OP_DRAW: begin
				for (int r = 0; r < GLYPH_H; r++) begin
					pattern = font_rows[code * GLYPH_H + r];
					// bit 7 is the leftmost column
					for (int c = 0; c < GLYPH_W; c++)
						pending_writes.push_back(make_write(longint'(x) + c, longint'(y) + r,
							pattern[GLYPH_W-1-c] ? fg : bg,
							(r == GLYPH_H-1) && (c == GLYPH_W-1)));
				end
			end
			default: ;
		endcase
	endfunction

	// near the screen edge, inside it, or anywhere in the field range
	function automatic logic [gfb_pkg::POS_W-1:0] pick_coord(longint unsigned dim);
		int unsigned lo, hi;
		case ($urandom_range(0, 3))
			0: return gfb_pkg::POS_W'($urandom_range(0, 4095));
			1: begin
				lo = 32'((dim > 10) ? dim - 10 : 0);
				hi = 32'((dim + 2 > 4095) ? 4095 : dim + 2);
				return gfb_pkg::POS_W'($urandom_range(lo, hi));
			end
			default: return (dim > 1) ?
				gfb_pkg::POS_W'($urandom_range(0, 32'(dim - 1))) : '0;
		endcase
	endfunction

	task automatic send_word(gfb_pkg::op_t o, logic [gfb_pkg::CODE_W-1:0] code,
		logic [gfb_pkg::GROW_W-1:0] grow, logic [gfb_pkg::BITS_W-1:0] bits,
		logic [gfb_pkg::POS_W-1:0] x, logic [gfb_pkg::POS_W-1:0] y,
		logic [gfb_pkg::COLOR_W-1:0] fg, logic [gfb_pkg::COLOR_W-1:0] bg);
		int unsigned gap;
		gap = pacing_off ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= o;
		char_code <= code;
		glyph_row <= grow;
		row_bits <= bits;
		pos_x <= x;
		pos_y <= y;
		fg_color <= fg;
		bg_color <= bg;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		compute_pixel_writes(o, code, grow, bits, x, y, fg, bg);
		if (o == OP_UNUSED)
			noise_sent++;
		else
			items_sent++;
		if (o == gfb_pkg::OP_DRAW)
			draws_sent++;
		if (o == gfb_pkg::OP_PUT)
			puts_sent++;
	endtask

	task automatic send_random(gfb_pkg::op_t o, logic [gfb_pkg::CODE_W-1:0] code);
		send_word(o, code, gfb_pkg::GROW_W'($urandom_range(0, 7)),
			gfb_pkg::BITS_W'($urandom_range(0, 255)),
			pick_coord(fb_width), pick_coord(fb_height), $urandom, $urandom);
	endtask

	task automatic load_glyph_random(logic [gfb_pkg::CODE_W-1:0] code);
		bit was_ready;
		was_ready = glyph_ready(code);
		for (int r = 0; r < GLYPH_H; r++)
			send_word(gfb_pkg::OP_LOAD, code, gfb_pkg::GROW_W'(r),
				gfb_pkg::BITS_W'($urandom_range(0, 255)),
				gfb_pkg::POS_W'($urandom_range(0, 4095)),
				gfb_pkg::POS_W'($urandom_range(0, 4095)), $urandom, $urandom);
		if (!was_ready)
			ready_codes.push_back(code);
	endtask

	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// called only while idle; three back-to-back register writes
	task automatic set_screen(bit present, int unsigned w, int unsigned h);
		cfg_we <= 1'b1;
		cfg_index <= gfb_pkg::CFG_PRESENT;
		cfg_data <= gfb_pkg::DIM_W'(present);
		@(posedge clk);
		cfg_index <= gfb_pkg::CFG_WIDTH;
		cfg_data <= gfb_pkg::DIM_W'(w);
		@(posedge clk);
		cfg_index <= gfb_pkg::CFG_HEIGHT;
		cfg_data <= gfb_pkg::DIM_W'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		fb_present = present;
		fb_width = w;
		fb_height = h;
		screens_used++;
	endtask

	// sink pacing: random stall before each word
	initial begin : sink_pacing
		int unsigned hold;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			hold = pacing_off ? 0 : $urandom_range(0, MAX_WAIT);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	always @(posedge clk) begin : word_check
		pixel_write_t exp_w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_writes.size() == 0) begin
				$error("unexpected word: index %0d color %h", pixel_index, pixel_color);
				mismatches++;
			end else begin
				exp_w = pending_writes.pop_front();
				words_checked++;
				if (exp_w.write_valid)
					valid_words++;
				if (write_valid !== exp_w.write_valid) begin
					$error("write_valid: expected %0d, got %0d", exp_w.write_valid, write_valid);
					mismatches++;
				end
				if (pixel_index !== exp_w.pixel_index) begin
					$error("pixel_index: expected %0d, got %0d", exp_w.pixel_index, pixel_index);
					mismatches++;
				end
				if (pixel_color !== exp_w.pixel_color) begin
					$error("pixel_color: expected %h, got %h", exp_w.pixel_color, pixel_color);
					mismatches++;
				end
				if (last !== exp_w.last) begin
					$error("last: expected %0d, got %0d", exp_w.last, last);
					mismatches++;
				end
			end
		end
	end

	// reset settings: framebuffer absent, so the write must be suppressed
	task automatic test_unconfigured_screen();
		send_word(gfb_pkg::OP_PUT, 8'h00, 3'd0, 8'h00, 12'd0, 12'd0, 32'hFFFF_FFFF, 32'h0);
		drain_and_settle();
	endtask

	task automatic test_glyph_extremes();
		logic [gfb_pkg::BITS_W-1:0] rows_a [GLYPH_H];
		rows_a = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h81, 8'h7E};
		set_screen(1'b1, 4096, 4096);
		for (int r = 0; r < GLYPH_H; r++)
			send_word(gfb_pkg::OP_LOAD, 8'h41, gfb_pkg::GROW_W'(r), rows_a[r], 12'hFFF,
				12'h000, 32'h0, 32'hFFFF_FFFF);
		// rows loaded bottom-up to exercise row addressing
		for (int r = GLYPH_H - 1; r >= 0; r--)
			send_word(gfb_pkg::OP_LOAD, 8'hFF, gfb_pkg::GROW_W'(r), ~rows_a[r], 12'h000,
				12'hFFF, 32'hFFFF_FFFF, 32'h0);
		ready_codes.push_back(8'h41);
		ready_codes.push_back(8'hFF);
		send_word(gfb_pkg::OP_DRAW, 8'h41, 3'd7, 8'hFF, 12'd0, 12'd0, 32'hFFFF_FFFF, 32'h0);
		// bottom-right corner: most pixels fall past the 24-bit index space
		send_word(gfb_pkg::OP_DRAW, 8'hFF, 3'd0, 8'h00, 12'hFFF, 12'hFFF, 32'h0,
			32'hFFFF_FFFF);
		send_word(gfb_pkg::OP_PUT, 8'hFF, 3'd7, 8'hFF, 12'hFFF, 12'hFFF, 32'hA5A5_5A5A,
			32'h0);
		send_word(gfb_pkg::OP_PUT, 8'h00, 3'd0, 8'h00, 12'd0, 12'd0, 32'h5A5A_A5A5,
			32'hFFFF_FFFF);
		send_word(OP_UNUSED, 8'h41, 3'd2, 8'h3C, 12'd5, 12'd5, 32'h1234_5678, 32'h8765_4321);
		drain_and_settle();
	endtask

	// 8x8 screen: a glyph fills it exactly; index equal to width*height is out
	task automatic test_exact_fit_bounds();
		set_screen(1'b1, 8, 8);
		send_word(gfb_pkg::OP_DRAW, 8'h41, 3'd0, 8'h00, 12'd0, 12'd0, 32'hCAFE_0001,
			32'h0BAD_0002);
		send_word(gfb_pkg::OP_PUT, 8'h00, 3'd0, 8'h00, 12'd7, 12'd7, 32'h0000_00FF, 32'h0);
		send_word(gfb_pkg::OP_PUT, 8'h00, 3'd0, 8'h00, 12'd0, 12'd8, 32'h0000_FF00, 32'h0);
		drain_and_settle();
	endtask

	task automatic run_random_mix(int unsigned budget, bit pause_midway);
		int unsigned start, sel;
		logic [gfb_pkg::CODE_W-1:0] code;
		start = items_sent;
		while (items_sent - start < budget) begin
			if (pause_midway && (items_sent - start >= budget / 2)) begin
				drain_and_settle();
				pause_midway = 1'b0;
			end
			sel = $urandom_range(0, 99);
			code = gfb_pkg::CODE_W'($urandom_range(0, 255));
			if (sel < 14)
				load_glyph_random(code);
			else if (sel < 24)
				send_random(gfb_pkg::OP_LOAD, code);
			else if (sel < 62) begin
				if (!glyph_ready(code))
					code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
				send_random(gfb_pkg::OP_DRAW, code);
			end else if (sel < 93)
				send_random(gfb_pkg::OP_PUT, code);
			else
				send_random(OP_UNUSED, code);
		end
		drain_and_settle();
	endtask

	task automatic test_random_screens();
		bit          present_l [8] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
		int unsigned width_l [8] = '{640, 640, 0, 4096, 1, 4096, 13, 0};
		int unsigned height_l [8] = '{480, 480, 4096, 0, 1, 4096, 9, 0};
		width_l[7] = $urandom_range(1, 4096);
		height_l[7] = $urandom_range(1, 4096);
		for (int p = 0; p < 8; p++) begin
			pacing_off = (p == 3) || (p == 6);
			set_screen(present_l[p], width_l[p], height_l[p]);
			run_random_mix(25, p == 5);
		end
		pacing_off = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= gfb_pkg::CFG_PRESENT;
		cfg_data <= '0;
		in_valid <= 1'b0;
		op <= gfb_pkg::OP_LOAD;
		char_code <= '0;
		glyph_row <= '0;
		row_bits <= '0;
		pos_x <= '0;
		pos_y <= '0;
		fg_color <= '0;
		bg_color <= '0;
		fb_present = 1'b0;
		fb_width = 0;
		fb_height = 0;
		pacing_off = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unconfigured_screen();
		test_glyph_extremes();
		test_exact_fit_bounds();
		test_random_screens();
		drain_and_settle();

		$display("Sent %0d items (%0d draws, %0d single pixels, %0d unused-op words)",
			items_sent, draws_sent, puts_sent, noise_sent);
		$display("Checked %0d pixel words, %0d in bounds, over %0d screen settings",
			words_checked, valid_words, screens_used);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Timeout: %0d words still expected", pending_writes.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/gfb_pkg.sv
rtl/gfb_ram.sv
rtl/gfb_mul.sv
rtl/glyph_to_framebuffer_blitter_top.sv
rtl/gfb_checker.sv
verif/glyph_to_framebuffer_blitter_top_tb.sv
